// ===== hdl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg - shared constants and types of the cosine Taylor series unit
// Fixed-point formats, fold constants, series widths and the beat structs
// passed between the fold stage, the series pipeline and the top level.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int unsigned TERMS   = 50;   // series terms after the leading 1
  localparam int unsigned ANGLE_W = 32;   // Q16.16 angle
  localparam int unsigned COS_W   = 32;   // Q2.30 cosine

  // 6.28 in Q16.16, rounded to the nearest LSB
  localparam longint unsigned PERIOD = 64'd411566;

  // fold: bias to a non-negative value, then floor divide by reciprocal
  localparam int unsigned     U_W        = 33;
  localparam int unsigned     R_W        = 19;
  localparam longint unsigned FOLD_BIAS  = ((64'd1 << 31) + PERIOD - 1) / PERIOD * PERIOD;
  localparam int unsigned     FOLD_SHIFT = 3;
  localparam int unsigned     FOLD_FRAC  = 32;
  localparam int unsigned     FOLD_RCP_W = 17;
  localparam longint unsigned FOLD_RCP   = (64'd1 << (FOLD_FRAC + FOLD_SHIFT)) / PERIOD;
  localparam int unsigned     FQ_W       = 14;

  // series
  localparam int unsigned     SQ_W    = 2 * R_W;              // r*r, Q32
  localparam int unsigned     SCALE   = 32;
  localparam int unsigned     M_W     = 37;                   // term magnitude, Q30
  localparam int unsigned     P_W     = M_W + SQ_W - SCALE;   // m*x^2 before the divide
  localparam int unsigned     RC_W    = P_W;                  // divide reciprocal
  localparam int unsigned     ACC_W   = 40;                   // running sum, Q30
  localparam int unsigned     D_W     = 14;
  localparam int unsigned     REM_W   = 16;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] sq;
  } fold_beat_t;

  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] acc;
  } sum_beat_t;

endpackage

// ===== hdl/cts_fold.sv =====
// ----------------------------------------------------------------------------
// cts_fold - angle fold and square
// Floor modulo of the Q16.16 angle by the 6.28 period through a reciprocal
// multiply with one correction step, then the square of the folded angle.
// Six register stages, all advancing together on en.
// ----------------------------------------------------------------------------
module cts_fold (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [cts_pkg::ANGLE_W-1:0]   angle,
  output cts_pkg::fold_beat_t           result
);
  import cts_pkg::*;

  localparam int unsigned          STAGES = 6;
  localparam int unsigned          PROD_W = U_W - FOLD_SHIFT + FOLD_RCP_W;
  localparam logic [U_W:0]         BIAS   = (U_W + 1)'(FOLD_BIAS);
  localparam logic [FOLD_RCP_W-1:0] RCP   = FOLD_RCP_W'(FOLD_RCP);
  localparam logic [U_W-1:0]       PER_U  = U_W'(PERIOD);

  logic [STAGES-1:0] v;
  logic [ANGLE_W-1:0] a0;
  logic [U_W-1:0]    u1;
  logic [U_W-1:0]    u2;
  logic [U_W-1:0]    u3;
  logic [PROD_W-1:0] prod2;
  logic [U_W-1:0]    qp3;
  logic [R_W-1:0]    r4;
  logic [SQ_W-1:0]   sq5;
  logic [U_W:0]      biased;
  logic [U_W-1:0]    rem_e;

  // adding a multiple of the period keeps the residue and clears the sign
  assign biased = {{(U_W + 1 - ANGLE_W){a0[ANGLE_W-1]}}, a0} + BIAS;
  assign rem_e  = u3 - qp3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0    <= angle;
      u1    <= biased[U_W-1:0];
      u2    <= u1;
      prod2 <= PROD_W'(u1[U_W-1:FOLD_SHIFT]) * PROD_W'(RCP);
      u3    <= u2;
      // quotient estimate is exact or one short
      qp3   <= U_W'(prod2[FOLD_FRAC+FQ_W-1:FOLD_FRAC]) * PER_U;
      r4    <= (rem_e >= PER_U) ? R_W'(rem_e - PER_U) : R_W'(rem_e);
      sq5   <= SQ_W'(r4) * SQ_W'(r4);
    end
  end

  assign result.valid = v[STAGES-1];
  assign result.sq    = sq5;

endmodule

// ===== hdl/cts_series.sv =====
// ----------------------------------------------------------------------------
// cts_series - unrolled Taylor series pipeline
// One five-stage unit per term: m*x^2 in partial products, their sum, the
// divide by (2k-1)(2k) through a constant reciprocal, and a remainder fix.
// The running sum picks up each term one unit later; a last stage adds
// the final term.
// ----------------------------------------------------------------------------
module cts_series (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cts_pkg::fold_beat_t  src,
  output cts_pkg::sum_beat_t   result
);
  import cts_pkg::*;

  localparam int unsigned SPLIT_M = 19;
  localparam int unsigned SPLIT_S = 19;
  localparam int unsigned PP_W    = SPLIT_M + SPLIT_S;
  localparam int unsigned T_W     = M_W + SQ_W;
  localparam int unsigned SPLIT_P = 22;
  localparam int unsigned SPLIT_R = 21;
  localparam int unsigned PB_W    = SPLIT_P + RC_W - SPLIT_R;
  localparam int unsigned PR_W    = P_W + RC_W;
  localparam bit          SUB_LAST = (TERMS % 2) == 1;

  logic                    lv  [TERMS+1];
  logic [M_W-1:0]          lm  [TERMS+1];
  logic signed [ACC_W-1:0] la  [TERMS+1];
  logic [SQ_W-1:0]         lsq [TERMS+1];

  logic                    fv;
  logic signed [ACC_W-1:0] facc;
  logic signed [ACC_W-1:0] last_term;

  assign lv[0]  = src.valid;
  assign lm[0]  = M_W'(ONE_Q30);
  assign la[0]  = '0;
  assign lsq[0] = src.sq;

  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    localparam int unsigned      DIV      = (2 * k - 1) * (2 * k);
    localparam logic [RC_W-1:0]  RCP      = RC_W'((64'd1 << P_W) / DIV);
    localparam logic [REM_W-1:0] DIV_R    = REM_W'(D_W'(DIV));
    localparam bit               SUB_PREV = (k % 2) == 0;

    logic [4:0]              v;
    logic [PP_W-1:0]         pa_hh, pa_hl, pa_lh, pa_ll;
    logic [P_W-1:0]          p2;
    logic [PB_W-1:0]         pb_hh, pb_hl, pb_lh, pb_ll;
    logic [REM_W-1:0]        pl3, pl4;
    logic [M_W-1:0]          qe4;
    logic [M_W-1:0]          m5;
    logic signed [ACC_W-1:0] acc1, acc2, acc3, acc4, acc5;
    logic [SQ_W-1:0]         sq1, sq2, sq3, sq4, sq5;
    logic signed [ACC_W-1:0] m_term;
    logic [T_W-1:0]          t_sum;
    logic [PR_W-1:0]         pr_sum;
    logic [REM_W-1:0]        rem;

    assign m_term = $signed({{(ACC_W - M_W){1'b0}}, lm[k-1]});

    assign t_sum = (T_W'(pa_hh) << (SPLIT_M + SPLIT_S)) + (T_W'(pa_hl) << SPLIT_S)
                 + (T_W'(pa_lh) << SPLIT_M) + T_W'(pa_ll);

    assign pr_sum = (PR_W'(pb_hh) << (SPLIT_P + SPLIT_R)) + (PR_W'(pb_hl) << SPLIT_P)
                  + (PR_W'(pb_lh) << SPLIT_R) + PR_W'(pb_ll);

    // low bits suffice: the true remainder stays below twice the divisor
    assign rem = pl4 - REM_W'(qe4[REM_W-1:0] * DIV_R);

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= '0;
      end else if (en) begin
        v <= {v[3:0], lv[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // multiply m by x^2
        pa_hh <= PP_W'(lm[k-1][M_W-1:SPLIT_M]) * PP_W'(lsq[k-1][SQ_W-1:SPLIT_S]);
        pa_hl <= PP_W'(lm[k-1][M_W-1:SPLIT_M]) * PP_W'(lsq[k-1][SPLIT_S-1:0]);
        pa_lh <= PP_W'(lm[k-1][SPLIT_M-1:0]) * PP_W'(lsq[k-1][SQ_W-1:SPLIT_S]);
        pa_ll <= PP_W'(lm[k-1][SPLIT_M-1:0]) * PP_W'(lsq[k-1][SPLIT_S-1:0]);
        acc1  <= SUB_PREV ? la[k-1] - m_term : la[k-1] + m_term;
        sq1   <= lsq[k-1];
        // drop the Q32 scale
        p2    <= t_sum[T_W-1:SCALE];
        acc2  <= acc1;
        sq2   <= sq1;
        // divide by the term constant
        pb_hh <= PB_W'(p2[P_W-1:SPLIT_P]) * PB_W'(RCP[RC_W-1:SPLIT_R]);
        pb_hl <= PB_W'(p2[P_W-1:SPLIT_P]) * PB_W'(RCP[SPLIT_R-1:0]);
        pb_lh <= PB_W'(p2[SPLIT_P-1:0]) * PB_W'(RCP[RC_W-1:SPLIT_R]);
        pb_ll <= PB_W'(p2[SPLIT_P-1:0]) * PB_W'(RCP[SPLIT_R-1:0]);
        pl3   <= p2[REM_W-1:0];
        acc3  <= acc2;
        sq3   <= sq2;
        qe4   <= pr_sum[P_W+M_W-1:P_W];
        pl4   <= pl3;
        acc4  <= acc3;
        sq4   <= sq3;
        m5    <= (rem >= DIV_R) ? qe4 + M_W'(1) : qe4;
        acc5  <= acc4;
        sq5   <= sq4;
      end
    end

    assign lv[k]  = v[4];
    assign lm[k]  = m5;
    assign la[k]  = acc5;
    assign lsq[k] = sq5;
  end

  assign last_term = $signed({{(ACC_W - M_W){1'b0}}, lm[TERMS]});

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= lv[TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      facc <= SUB_LAST ? la[TERMS] - last_term : la[TERMS] + last_term;
    end
  end

  assign result.valid = fv;
  assign result.acc   = facc;

endmodule

// ===== hdl/cosine_taylor_series_unit.sv =====
// ----------------------------------------------------------------------------
// cosine_taylor_series_unit - cosine of a Q16.16 angle by Taylor series
// Folds the angle into [0, 6.28), evaluates 50 series terms in a fully
// unrolled pipeline and returns a saturated Q2.30 cosine.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one angle per beat on s_axis_tdata (signed Q16.16).
//   Master stream: one cosine per beat on m_axis_tdata (signed Q2.30),
//   in the order the angles came in, one result for every angle.
//   Throughput: one beat per cycle, sustained, as long as the receiver
//   keeps m_axis_tready high.
//   Pipeline: six fold/square stages, the first of which loads on the
//   accepting edge itself, five stages per term (partial products of
//   m*x^2, their sum, partial products of the reciprocal multiply, their
//   sum, remainder fix), one final sum stage and the output register.
//   Stall: the output register holds its beat; one skid register takes the
//   beat leaving the pipeline, then s_axis_tready drops and the whole
//   pipeline freezes until the output beat is taken.
//   Reset: rst (synchronous, active high) empties the pipeline, the output
//   register and the skid register; s_axis_tready is low during reset.
// ----------------------------------------------------------------------------
module cosine_taylor_series_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic signed [cts_pkg::ANGLE_W-1:0] s_axis_tdata,   // [31:0] angle
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic signed [cts_pkg::COS_W-1:0]   m_axis_tdata    // [31:0] cosine
);
  import cts_pkg::*;

  localparam logic signed [ACC_W-1:0] COS_MAX = ACC_W'((64'd1 << (COS_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] COS_MIN = ~COS_MAX;

  logic             en;
  logic             push;
  logic             pop;
  logic             out_v;
  logic             skid_v;
  logic [COS_W-1:0] out_d;
  logic [COS_W-1:0] skid_d;
  logic [COS_W-1:0] sat;
  fold_beat_t       fold_beat;
  sum_beat_t        sum_beat;

  assign en   = !skid_v && !rst;
  assign push = en && sum_beat.valid;
  assign pop  = out_v && m_axis_tready;

  cts_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .angle    (s_axis_tdata),
    .result   (fold_beat)
  );

  cts_series u_series (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .src    (fold_beat),
    .result (sum_beat)
  );

  always_comb begin
    if (sum_beat.acc > COS_MAX) begin
      sat = COS_MAX[COS_W-1:0];
    end else if (sum_beat.acc < COS_MIN) begin
      sat = COS_MIN[COS_W-1:0];
    end else begin
      sat = sum_beat.acc[COS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || pop) begin
      out_v  <= skid_v || push;
      skid_v <= 1'b0;
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  // drain the skid first; catch the pipeline beat there while output holds
  always_ff @(posedge clk) begin
    if (!out_v || pop) begin
      out_d <= skid_v ? skid_d : sat;
    end else if (push) begin
      skid_d <= sat;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = $signed(out_d);

endmodule

// ===== hdl/cts_checker.sv =====
// ----------------------------------------------------------------------------
// cts_checker - port-level checks of the cosine Taylor series unit
// Watches the two stream channels: output hold under stall, reset,
// and the link between back-pressure and the output register.
// ----------------------------------------------------------------------------
module cts_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic signed [cts_pkg::ANGLE_W-1:0] s_axis_tdata,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic signed [cts_pkg::COS_W-1:0]   m_axis_tdata
);
  import cts_pkg::*;

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled output beat");

  a_release : assert property (@(posedge clk) disable iff (rst)
    $rose(s_axis_tready) && !$past(rst) |-> $past(m_axis_tvalid && m_axis_tready))
    else $error("input released without an output beat taken");

endmodule

bind cosine_taylor_series_unit cts_checker u_cts_checker (.*);
